// ===== hw/rtl/urb_pkg.sv =====
// Shared constants, codes and types of the retransmission buffer.
`default_nettype none

package urb_pkg;

    localparam int unsigned DEPTH        = 1024;
    localparam int unsigned MAX_REPLAY   = 32;
    localparam int unsigned PAYLOAD_BITS = 64;

    localparam int unsigned SEQ_W    = 64;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned REQ_IN_W = 6;
    localparam int unsigned ADDR_W   = $clog2(DEPTH);
    localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
    localparam int unsigned REQ_W    = $clog2(MAX_REPLAY + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_REPLAY = 2'd2
    } urb_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_CHECK,
        ST_RUN
    } urb_state_t;

    typedef struct packed {
        logic             strobe;
        urb_kind_t        kind;
        logic [SEQ_W-1:0] seq;
        logic             last;
        logic             empty;
        logic [SEQ_W-1:0] last_acked;
        logic             overflow;
    } urb_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/urb_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module urb_ram #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned DATA_W = 64,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/urb_ctrl.sv =====
// Window registers, command sequencer and result registers.
`default_nettype none

module urb_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [urb_pkg::KIND_W-1:0]     kind,
    input  wire logic [urb_pkg::WORD_W-1:0]     payload,
    input  wire logic [urb_pkg::SEQ_W-1:0]      seq_in,
    input  wire logic [urb_pkg::REQ_IN_W-1:0]   replay_count,
    output logic                                busy,
    output urb_pkg::urb_result_t                result,
    output logic                                wr_en,
    output logic [urb_pkg::ADDR_W-1:0]          wr_addr,
    output logic [urb_pkg::PAYLOAD_BITS-1:0]    wr_data,
    output logic                                rd_en,
    output logic [urb_pkg::ADDR_W-1:0]          rd_addr
);

    import urb_pkg::*;

    urb_state_t         state_reg,  state_next;
    logic [SEQ_W-1:0]   base_reg,   base_next;
    logic [SEQ_W-1:0]   end_reg,    end_next;
    logic [ADDR_W-1:0]  wptr_reg,   wptr_next;
    logic [ADDR_W-1:0]  rptr_reg,   rptr_next;
    logic [SEQ_W-1:0]   seq_reg,    seq_next;
    logic [REQ_W-1:0]   req_reg,    req_next;
    logic [REQ_W-1:0]   remain_reg, remain_next;
    logic [SEQ_W-1:0]   off_reg,    off_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [CNT_W-1:0]   dist_reg,   dist_next;
    logic               below_reg,  below_next;

    logic               strobe_reg, strobe_next;
    urb_kind_t          rkind_reg,  rkind_next;
    logic [SEQ_W-1:0]   oseq_reg,   oseq_next;
    logic               last_reg,   last_next;
    logic               ovf_reg,    ovf_next;

    logic               accept;
    logic               full;
    logic               hit;
    logic [CNT_W-1:0]   avail;
    logic [REQ_W-1:0]   n_rec;
    logic [CNT_W:0]     ptr_sum;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign full   = ((end_reg - base_reg) >= SEQ_W'(DEPTH));

    always_comb
    begin
        hit     = !below_reg && (off_reg[SEQ_W-1:CNT_W] == '0)
                  && (off_reg[CNT_W-1:0] < cnt_reg);
        avail   = cnt_reg - off_reg[CNT_W-1:0];
        n_rec   = (32'(avail) < 32'(req_reg)) ? REQ_W'(avail) : req_reg;
        ptr_sum = (CNT_W+1)'(wptr_reg) + (CNT_W+1)'(DEPTH) - (CNT_W+1)'(dist_reg);
        if (ptr_sum >= (CNT_W+1)'(DEPTH))
        begin
            ptr_sum = ptr_sum - (CNT_W+1)'(DEPTH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            base_reg   <= '0;
            end_reg    <= '0;
            wptr_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            end_reg    <= end_next;
            wptr_reg   <= wptr_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rptr_reg   <= rptr_next;
        seq_reg    <= seq_next;
        req_reg    <= req_next;
        remain_reg <= remain_next;
        off_reg    <= off_next;
        cnt_reg    <= cnt_next;
        dist_reg   <= dist_next;
        below_reg  <= below_next;
        rkind_reg  <= rkind_next;
        oseq_reg   <= oseq_next;
        last_reg   <= last_next;
        ovf_reg    <= ovf_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        end_next    = end_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        seq_next    = seq_reg;
        req_next    = req_reg;
        remain_next = remain_reg;
        off_next    = off_reg;
        cnt_next    = cnt_reg;
        dist_next   = dist_reg;
        below_next  = below_reg;
        strobe_next = 1'b0;
        rkind_next  = rkind_reg;
        oseq_next   = oseq_reg;
        last_next   = last_reg;
        ovf_next    = ovf_reg;
        wr_en       = 1'b0;
        wr_addr     = wptr_reg;
        wr_data     = payload[PAYLOAD_BITS-1:0];
        rd_en       = 1'b0;
        rd_addr     = rptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_PUSH:
                        begin
                            strobe_next = 1'b1;
                            rkind_next  = KIND_PUSH;
                            last_next   = 1'b1;
                            if (full)
                            begin
                                oseq_next = '0;
                                ovf_next  = 1'b1;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                oseq_next = end_reg;
                                ovf_next  = 1'b0;
                                end_next  = end_reg + SEQ_W'(1);
                                wptr_next = (32'(wptr_reg) == DEPTH - 1) ? '0
                                            : wptr_reg + ADDR_W'(1);
                            end
                        end
                        KIND_ACK:
                        begin
                            strobe_next = 1'b1;
                            rkind_next  = KIND_ACK;
                            oseq_next   = '0;
                            last_next   = 1'b1;
                            ovf_next    = 1'b0;
                            if (seq_in >= base_reg)
                            begin
                                base_next = (seq_in < end_reg) ? seq_in + SEQ_W'(1)
                                                               : end_reg;
                            end
                        end
                        KIND_REPLAY:
                        begin
                            seq_next   = seq_in;
                            req_next   = (32'(replay_count) > MAX_REPLAY)
                                         ? REQ_W'(MAX_REPLAY) : REQ_W'(replay_count);
                            state_next = ST_OFFSET;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_OFFSET:
            begin
                off_next   = seq_reg - base_reg;
                below_next = (seq_reg < base_reg);
                cnt_next   = CNT_W'(end_reg - base_reg);
                dist_next  = CNT_W'(end_reg - seq_reg);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                rptr_next   = ADDR_W'(ptr_sum);
                remain_next = n_rec;
                state_next  = (hit && (n_rec != '0)) ? ST_RUN : ST_IDLE;
            end
            ST_RUN:
            begin
                rd_en       = 1'b1;
                strobe_next = 1'b1;
                rkind_next  = KIND_REPLAY;
                oseq_next   = seq_reg;
                last_next   = (remain_reg == REQ_W'(1));
                ovf_next    = 1'b0;
                seq_next    = seq_reg + SEQ_W'(1);
                remain_next = remain_reg - REQ_W'(1);
                rptr_next   = (32'(rptr_reg) == DEPTH - 1) ? '0 : rptr_reg + ADDR_W'(1);
                if (remain_reg == REQ_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.strobe     = strobe_reg;
    assign result.kind       = rkind_reg;
    assign result.seq        = oseq_reg;
    assign result.last       = last_reg;
    assign result.empty      = (end_reg == base_reg);
    assign result.last_acked = base_reg - SEQ_W'(1);
    assign result.overflow   = ovf_reg;

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (end_reg - base_reg) <= SEQ_W'(DEPTH))
        else $error("kept count beyond ring depth");

    a_run_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (remain_reg != '0))
        else $error("replay running with no record left");

    a_ovf_push: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && ovf_reg) |-> (rkind_reg == KIND_PUSH))
        else $error("overflow on non-push result");

    a_status_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (rkind_reg != KIND_REPLAY)) |-> $past(accept))
        else $error("push or ack result without accepted word");

    a_no_write_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_IDLE) && !rd_en)
        else $error("store written during replay");

endmodule

`default_nettype wire

// ===== hw/rtl/unacked_retransmit_buffer_top.sv =====
// Top level of the unacknowledged-record retransmission buffer.
// Push and ack: result strobe in the cycle after accept; busy stays low, one word per cycle.
// Replay: busy through setup and run (n records, n <= 32); setup is the offset and check
// states, then the payload RAM read port gives one record per cycle in the run state.
// Reset clears the window to empty; the payload RAM is not cleared and needs no sweep.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module unacked_retransmit_buffer_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [urb_pkg::KIND_W-1:0]     kind,
    input  wire logic [urb_pkg::WORD_W-1:0]     payload,
    input  wire logic [urb_pkg::SEQ_W-1:0]      seq_in,
    input  wire logic [urb_pkg::REQ_IN_W-1:0]   replay_count,
    output logic                                result_strobe,
    output logic [urb_pkg::KIND_W-1:0]          result_kind,
    output logic [urb_pkg::SEQ_W-1:0]           seq_out,
    output logic [urb_pkg::WORD_W-1:0]          payload_out,
    output logic                                last,
    output logic                                empty_res,
    output logic [urb_pkg::SEQ_W-1:0]           last_acked,
    output logic                                overflow
);

    import urb_pkg::*;

    urb_result_t             res;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [PAYLOAD_BITS-1:0] wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [PAYLOAD_BITS-1:0] rd_data;

    urb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .payload      (payload),
        .seq_in       (seq_in),
        .replay_count (replay_count),
        .busy         (busy),
        .result       (res),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr)
    );

    urb_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (PAYLOAD_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign result_strobe = res.strobe;
    assign result_kind   = res.kind;
    assign seq_out       = res.seq;
    assign payload_out   = (res.kind == KIND_REPLAY) ? WORD_W'(rd_data) : '0;
    assign last          = res.last;
    assign empty_res     = res.empty;
    assign last_acked    = res.last_acked;
    assign overflow      = res.overflow;

endmodule

`default_nettype wire
